// ===== hdl/sorted_list_store_defines.svh =====
// ----------------------------------------------------------------------------
// sorted_list_store assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_STORE_DEFINES_SVH
`define SORTED_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS
// Plain property, sampled on clk, off while reset is asserted.
`define SLST_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies consequence in the next.
`define SLST_ASSERT_NEXT(name, clk, rst_n, cond, conseq, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`else
`define SLST_ASSERT(name, clk, rst_n, prop, msg)
`define SLST_ASSERT_NEXT(name, clk, rst_n, cond, conseq, msg)
`endif

`endif

// ===== hdl/slst_pkg.sv =====
// ----------------------------------------------------------------------------
// slst_pkg
// Shared codes and types of the sorted list store.
// ----------------------------------------------------------------------------
package slst_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int ITEM_W   = 16;
    localparam int COUNT_W  = 6;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEL1   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DELALL = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DUMP   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     found;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DELALL,
        S_DUMP
    } state_t;

endpackage

// ===== hdl/slst_cell.sv =====
// ----------------------------------------------------------------------------
// slst_cell
// One list slot: compares against the broadcast operand and shifts.
// ----------------------------------------------------------------------------
module slst_cell #(
    parameter int VALUE_BITS = 16,
    parameter int FILL_W     = 6,
    parameter int INDEX      = 0
) (
    input  logic                   clk,
    input  slst_pkg::cell_ctrl_t   ctrl,
    input  logic [VALUE_BITS-1:0]  operand,
    input  logic [FILL_W-1:0]      fill,
    input  logic [VALUE_BITS-1:0]  head,
    input  logic [VALUE_BITS-1:0]  prev_slot,
    input  logic                   prev_gt,
    input  logic [VALUE_BITS-1:0]  next_slot,
    output logic [VALUE_BITS-1:0]  slot,
    output logic                   gt,
    output logic                   match
);
    import slst_pkg::*;

    logic [VALUE_BITS-1:0] slot_reg;
    logic [VALUE_BITS-1:0] slot_next;
    logic                  in_use;
    logic                  ge;
    logic                  at_tail;

    assign in_use  = FILL_W'(INDEX) < fill;
    assign at_tail = FILL_W'(INDEX + 1) == fill;
    // slots past the fill count rank above any operand, so insert lands at the end
    assign gt      = !in_use || ($signed(slot_reg) > $signed(operand));
    assign ge      = in_use && ($signed(slot_reg) >= $signed(operand));
    assign match   = in_use && (slot_reg == operand);
    assign slot    = slot_reg;

    always_comb
    begin
        slot_next = slot_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (prev_gt)
                    slot_next = prev_slot;
                else if (gt)
                    slot_next = operand;
            end
            CELL_DELETE:
            begin
                // from the first match onward the list closes up by one
                if (ctrl.found && ge)
                    slot_next = next_slot;
            end
            CELL_ROTATE:
            begin
                slot_next = at_tail ? head : next_slot;
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== hdl/sorted_list_store.sv =====
// ----------------------------------------------------------------------------
// sorted_list_store
// Ascending sorted list of signed values held in a chain of slot cells.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready/s_tdata (action and value); results
// leave on m_tvalid/m_tready/m_tdata with m_tlast on the final result of an
// action. The input is taken only when the control is idle and the output
// register is empty or being drained.
// Insert, delete-first, clear and unused codes: the result shows in the output
// register the cycle after the item is taken.
// Delete-all: one entry freed per cycle by a single-step left shift through
// the cells, then one result.
// Dump: one result per stored entry, one per cycle while the receiver takes
// them; the list rotates through cell 0 and is back in place at the end.
// An empty list gives a single result for dump and the deletes.
// A stalled receiver holds the result, freezes dump and keeps the input
// waiting; delete-all starts with the output empty, so it never waits.
// Reset empties the list (fill count to zero) and drops any pending result;
// slot contents are not cleared.
// ----------------------------------------------------------------------------
`include "sorted_list_store_defines.svh"

module sorted_list_store #(
    parameter int CAPACITY   = 32,
    parameter int VALUE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[2:0], value[18:3], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // item[15:0], entries[21:16], removed[27:22],
                                   // status[29:28], zero pad
    output logic        m_tlast
);
    import slst_pkg::*;

    localparam int FILL_W = $clog2(CAPACITY + 1);

    state_t                state_reg, state_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [FILL_W-1:0]     cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] opnd_reg, opnd_next;
    logic                  ov_reg;
    logic [ITEM_W-1:0]     item_reg, item_next;
    logic [COUNT_W-1:0]    entries_reg, entries_next;
    logic [COUNT_W-1:0]    removed_reg, removed_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  last_reg, last_next;

    logic                  accept;
    logic                  out_free;
    logic                  emit;
    logic [ACTION_W-1:0]   action;
    logic [ITEM_W-1:0]     value;
    logic [VALUE_BITS+15:0] value_ext;
    logic [VALUE_BITS-1:0] in_v;
    logic [VALUE_BITS-1:0] operand;
    cell_ctrl_t            ctrl;
    cell_op_t              cell_op;
    logic                  found;

    logic [VALUE_BITS-1:0] slot_w [CAPACITY];
    logic [VALUE_BITS-1:0] prev_w [CAPACITY];
    logic [VALUE_BITS-1:0] nxt_w  [CAPACITY];
    logic [CAPACITY:0]     gt_chain;
    logic [CAPACITY-1:0]   match_w;

    function automatic logic [COUNT_W-1:0] to_count(input logic [FILL_W-1:0] c);
        logic [FILL_W+COUNT_W-1:0] t;
        t = {{COUNT_W{1'b0}}, c};
        return t[COUNT_W-1:0];
    endfunction

    function automatic logic [ITEM_W-1:0] to_item(input logic [VALUE_BITS-1:0] s);
        logic [VALUE_BITS+ITEM_W-1:0] t;
        t = {{ITEM_W{1'b0}}, s};
        return t[ITEM_W-1:0];
    endfunction

    assign action    = s_tdata[ACTION_W-1:0];
    assign value     = s_tdata[ACTION_W+ITEM_W-1:ACTION_W];
    // the field is taken as VALUE_BITS wide: cut down, or filled with zeros above
    assign value_ext = {{VALUE_BITS{1'b0}}, value};
    assign in_v      = value_ext[VALUE_BITS-1:0];

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign operand  = (state_reg == S_IDLE) ? in_v : opnd_reg;

    // ---------------- cell chain ----------------
    assign gt_chain[0] = 1'b0;
    assign found       = |match_w;
    assign ctrl.op     = cell_op;
    assign ctrl.found  = found;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign prev_w[i] = slot_w[i];
        end
        else
        begin : g_mid
            assign prev_w[i] = slot_w[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign nxt_w[i] = slot_w[i];
        end
        else
        begin : g_inner
            assign nxt_w[i] = slot_w[i+1];
        end

        slst_cell #(
            .VALUE_BITS (VALUE_BITS),
            .FILL_W     (FILL_W),
            .INDEX      (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .operand   (operand),
            .fill      (fill_reg),
            .head      (slot_w[0]),
            .prev_slot (prev_w[i]),
            .prev_gt   (gt_chain[i]),
            .next_slot (nxt_w[i]),
            .slot      (slot_w[i]),
            .gt        (gt_chain[i+1]),
            .match     (match_w[i])
        );
    end

    // ---------------- control: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && fill_reg != '0)
                begin
                    if (action == ACT_DELALL)
                        state_next = S_DELALL;
                    else if (action == ACT_DUMP)
                        state_next = S_DUMP;
                end
            end
            S_DELALL:
            begin
                if (!found && out_free)
                    state_next = S_IDLE;
            end
            S_DUMP:
            begin
                if (out_free && (cnt_reg + 1'b1 == fill_reg))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- control: outputs ----------------
    always_comb
    begin
        cell_op      = CELL_HOLD;
        emit         = 1'b0;
        fill_next    = fill_reg;
        cnt_next     = cnt_reg;
        opnd_next    = opnd_reg;
        item_next    = '0;
        entries_next = to_count(fill_reg);
        removed_next = '0;
        status_next  = ST_OK;
        last_next    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (action)
                        ACT_INSERT:
                        begin
                            emit = 1'b1;
                            if (fill_reg == FILL_W'(CAPACITY))
                                status_next = ST_FULL;
                            else
                            begin
                                cell_op      = CELL_INSERT;
                                fill_next    = fill_reg + 1'b1;
                                entries_next = to_count(fill_reg + 1'b1);
                            end
                        end
                        ACT_DEL1:
                        begin
                            emit = 1'b1;
                            if (fill_reg == '0)
                                status_next = ST_EMPTY;
                            else if (found)
                            begin
                                cell_op      = CELL_DELETE;
                                fill_next    = fill_reg - 1'b1;
                                entries_next = to_count(fill_reg - 1'b1);
                                removed_next = COUNT_W'(1);
                            end
                            else
                                status_next = ST_NOTFOUND;
                        end
                        ACT_DELALL:
                        begin
                            opnd_next = in_v;
                            cnt_next  = '0;
                            if (fill_reg == '0)
                            begin
                                emit        = 1'b1;
                                status_next = ST_EMPTY;
                            end
                        end
                        ACT_DUMP:
                        begin
                            cnt_next = '0;
                            if (fill_reg == '0)
                            begin
                                emit        = 1'b1;
                                status_next = ST_EMPTY;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            emit         = 1'b1;
                            fill_next    = '0;
                            entries_next = '0;
                            removed_next = to_count(fill_reg);
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_DELALL:
            begin
                if (found)
                begin
                    // one matching entry leaves per cycle
                    cell_op   = CELL_DELETE;
                    fill_next = fill_reg - 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else if (out_free)
                begin
                    emit         = 1'b1;
                    removed_next = to_count(cnt_reg);
                    status_next  = (cnt_reg != '0) ? ST_OK : ST_NOTFOUND;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    cell_op   = CELL_ROTATE;
                    emit      = 1'b1;
                    item_next = to_item(slot_w[0]);
                    last_next = (cnt_reg + 1'b1 == fill_reg);
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            cnt_reg   <= cnt_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        if (emit)
        begin
            item_reg    <= item_next;
            entries_reg <= entries_next;
            removed_reg <= removed_next;
            status_reg  <= status_next;
            last_reg    <= last_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, status_reg, removed_reg, entries_reg, item_reg};

    // ---------------- assertions ----------------
    `SLST_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= FILL_W'(CAPACITY),
        "fill count beyond capacity")
    `SLST_ASSERT(a_dump_cnt, clk, rst_n, (state_reg != S_DUMP) || (cnt_reg < fill_reg),
        "dump counter past fill count")
    `SLST_ASSERT_NEXT(a_delall_enter, clk, rst_n,
        accept && (action == ACT_DELALL) && (fill_reg != '0),
        state_reg == S_DELALL, "delete-all did not start")
    `SLST_ASSERT_NEXT(a_insert_grow, clk, rst_n,
        accept && (action == ACT_INSERT) && (fill_reg < FILL_W'(CAPACITY)),
        fill_reg == $past(fill_reg) + 1'b1, "insert did not grow the list")

endmodule
